@@ rtl/scfl_pkg.sv @@
// Shared types, codes and constants of the size-class free-list allocator.
package scfl_pkg;

  localparam int unsigned CLASS_COUNT = 4;
  localparam int unsigned ONE_MB      = 1048576;
  localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
  localparam logic [22:0] POOL_RESET  = 23'd1048576;
  localparam logic [22:0] MAX_CLASS   = 23'd65536;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  localparam logic [1:0] CLS_64    = 2'd0;
  localparam logic [1:0] CLS_1K    = 2'd1;
  localparam logic [1:0] CLS_4K    = 2'd2;
  localparam logic [1:0] CLS_64K   = 2'd3;

  typedef struct packed {
    logic capture;
    logic alloc_wb;
    logic free_push;
    logic init_start;
    logic prep0;
    logic prep1;
    logic prep2;
    logic carve_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       alloc_ok;
    logic       carve_done;
  } ctrl_sts_t;

  function automatic logic [16:0] class_bytes(input logic [1:0] cls);
    logic [16:0] b;
    unique case (cls)
      CLS_64:  b = 17'd64;
      CLS_1K:  b = 17'd1024;
      CLS_4K:  b = 17'd4096;
      default: b = 17'd65536;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/scfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scfl_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/scfl_ctrl.sv @@
// Controller state machine that sequences allocate, free and pool carving.
module scfl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  scfl_pkg::ctrl_sts_t sts,
  output scfl_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_ALLOC_WB = 7'b0000100,
    S_PREP0    = 7'b0001000,
    S_PREP1    = 7'b0010000,
    S_PREP2    = 7'b0100000,
    S_CARVE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.mode)
          scfl_pkg::MODE_ALLOC: begin
            // The link read of the head block was issued this cycle.
            if (sts.alloc_ok) begin
              state_nxt = S_ALLOC_WB;
            end else begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          scfl_pkg::MODE_FREE: begin
            cmd.free_push = 1'b1;
            cmd.finish    = 1'b1;
            state_nxt     = S_IDLE;
          end
          scfl_pkg::MODE_INIT: begin
            cmd.init_start = 1'b1;
            state_nxt      = S_PREP0;
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_ALLOC_WB: begin
        cmd.alloc_wb = 1'b1;
        cmd.finish   = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_PREP0: begin
        cmd.prep0 = 1'b1;
        state_nxt = S_PREP1;
      end
      S_PREP1: begin
        cmd.prep1 = 1'b1;
        state_nxt = S_PREP2;
      end
      S_PREP2: begin
        cmd.prep2 = 1'b1;
        state_nxt = S_CARVE;
      end
      S_CARVE: begin
        if (sts.carve_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.carve_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_wb_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC_WB) |-> $past(state_r == S_EXEC))
    else $error("allocate write-back without a preceding execute cycle");

  a_prep_to_carve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP2) |=> (state_r == S_CARVE))
    else $error("carving did not follow the last preparation step");

endmodule

@@ rtl/scfl_dp.sv @@
// Datapath: list heads, link memory, block counts, carving counters and result word.
module scfl_dp #(
  parameter int unsigned MAX_POOL_BYTES = 4194304,
  parameter int unsigned HEADER_BYTES   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scfl_pkg::ctrl_cmd_t cmd,
  output scfl_pkg::ctrl_sts_t sts,
  input  logic                cfg_we,
  input  logic [22:0]         cfg_pool_bytes,
  input  logic [1:0]          in_mode,
  input  logic [22:0]         in_size_bytes,
  input  logic [21:0]         in_block_offset,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [21:0]         out_granted_offset,
  output logic [16:0]         out_granted_bytes,
  output logic [16:0]         out_free_count
);

  localparam int unsigned GRANULES = MAX_POOL_BYTES / 64;
  localparam int unsigned GW       = $clog2(GRANULES);
  localparam int unsigned OFF_W    = $clog2(MAX_POOL_BYTES);
  localparam int unsigned LW       = OFF_W + 1;
  localparam int unsigned CW       = OFF_W - 5;

  function automatic logic [GW-1:0] gran(input logic [OFF_W-1:0] o);
    return GW'(o >> 6);
  endfunction

  // Input word and configuration.
  logic [1:0]  mode_r;
  logic [22:0] size_r;
  logic [21:0] off_r;
  logic [22:0] pool_bytes_r;

  // List state.
  logic [OFF_W-1:0] head_r [scfl_pkg::CLASS_COUNT];
  logic [16:0]      count_r, count_nxt;

  // Carving state.
  logic [LW-1:0]    left_r;
  logic [CW-1:0]    n_r [scfl_pkg::CLASS_COUNT];
  logic [1:0]       carve_cls_r;
  logic [LW-1:0]    carve_off_r;

  // Result word.
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [21:0] out_offset_r;
  logic [16:0] out_bytes_r;
  logic [16:0] out_count_r;

  logic [1:0]       alloc_cls, free_cls, cls_use;
  logic             free_found, too_large, bad_free, empty, grant;
  logic [OFF_W-1:0] head_cur, push_off, rdata;
  logic [CW-1:0]    n_cur;
  logic             push_en;
  logic             mem_we;
  logic [GW-1:0]    mem_waddr;
  logic [OFF_W-1:0] mem_wdata;
  logic [1:0]       status_w;
  logic [31:0]      tot32, left32;
  logic [LW-16-1:0] q64k;
  logic [2:0]       cap64k, n64k;
  logic [LW-1:0]    left_1k;

  always_comb begin
    priority if (size_r <= 23'd64) begin
      alloc_cls = scfl_pkg::CLS_64;
    end else if (size_r <= 23'd1024) begin
      alloc_cls = scfl_pkg::CLS_1K;
    end else if (size_r <= 23'd4096) begin
      alloc_cls = scfl_pkg::CLS_4K;
    end else begin
      alloc_cls = scfl_pkg::CLS_64K;
    end
  end

  always_comb begin
    free_found = 1'b1;
    priority if (size_r == 23'd64) begin
      free_cls = scfl_pkg::CLS_64;
    end else if (size_r == 23'd1024) begin
      free_cls = scfl_pkg::CLS_1K;
    end else if (size_r == 23'd4096) begin
      free_cls = scfl_pkg::CLS_4K;
    end else if (size_r == scfl_pkg::MAX_CLASS) begin
      free_cls = scfl_pkg::CLS_64K;
    end else begin
      free_cls   = scfl_pkg::CLS_64;
      free_found = 1'b0;
    end
  end

  always_comb begin
    unique case (mode_r)
      scfl_pkg::MODE_INIT: cls_use = carve_cls_r;
      scfl_pkg::MODE_FREE: cls_use = free_cls;
      default:             cls_use = alloc_cls;
    endcase
  end

  assign head_cur  = head_r[cls_use];
  assign n_cur     = n_r[carve_cls_r];
  assign too_large = (size_r > scfl_pkg::MAX_CLASS);
  assign empty     = (head_cur == '0);
  assign bad_free  = !free_found || (32'(off_r) < HEADER_BYTES) ||
                     (32'(off_r >> 6) >= GRANULES);
  assign grant     = (mode_r == scfl_pkg::MODE_ALLOC) && !too_large && !empty;

  assign push_off = (mode_r == scfl_pkg::MODE_INIT) ? OFF_W'(carve_off_r) : OFF_W'(off_r);
  assign push_en  = (cmd.free_push && !bad_free) || (cmd.carve_step && (n_cur != '0));

  // A popped block's link is cleared so that a block freed twice pops only twice.
  assign mem_we    = push_en || cmd.alloc_wb;
  assign mem_waddr = cmd.alloc_wb ? gran(head_cur) : gran(push_off);
  assign mem_wdata = cmd.alloc_wb ? '0 : head_cur;

  scfl_ram #(
    .WIDTH (OFF_W),
    .DEPTH (GRANULES)
  ) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (gran(head_cur)),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.init_start) begin
      count_nxt = '0;
    end else if (push_en) begin
      if (count_r != scfl_pkg::COUNT_MAX) begin
        count_nxt = count_r + 17'd1;
      end
    end else if (cmd.alloc_wb) begin
      if (count_r != '0) begin
        count_nxt = count_r - 17'd1;
      end
    end
  end

  // Carving preparation arithmetic.
  always_comb begin
    tot32  = {9'd0, pool_bytes_r[22:6], 6'd0};
    if (tot32 > MAX_POOL_BYTES) begin
      tot32 = MAX_POOL_BYTES;
    end
    left32 = (tot32 > HEADER_BYTES) ? (tot32 - HEADER_BYTES) : 32'd0;
    q64k   = left_r[LW-1:16];
    cap64k = (32'(left_r) > scfl_pkg::ONE_MB) ? 3'd4 : 3'd2;
    n64k   = (32'(q64k) < 32'(cap64k)) ? 3'(q64k) : cap64k;
    left_1k = left_r - ((left_r >> 11) << 10);
  end

  always_comb begin
    unique case (mode_r)
      scfl_pkg::MODE_ALLOC: status_w = too_large ? scfl_pkg::ST_TOO_LARGE :
                                       (empty ? scfl_pkg::ST_EMPTY : scfl_pkg::ST_OK);
      scfl_pkg::MODE_FREE:  status_w = bad_free ? scfl_pkg::ST_BAD_FREE : scfl_pkg::ST_OK;
      default:              status_w = scfl_pkg::ST_OK;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_bytes_r <= scfl_pkg::POOL_RESET;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < scfl_pkg::CLASS_COUNT; i++) begin
        head_r[i[1:0]] <= '0;
      end
    end else begin
      if (cfg_we) begin
        pool_bytes_r <= cfg_pool_bytes;
      end
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.init_start) begin
        for (int i = 0; i < scfl_pkg::CLASS_COUNT; i++) begin
          head_r[i[1:0]] <= '0;
        end
      end else if (push_en) begin
        head_r[cls_use] <= push_off;
      end else if (cmd.alloc_wb) begin
        head_r[cls_use] <= rdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      size_r <= in_size_bytes;
      off_r  <= in_block_offset;
    end
    if (cmd.init_start) begin
      left_r      <= LW'(left32);
      carve_cls_r <= scfl_pkg::CLS_64K;
      carve_off_r <= LW'(HEADER_BYTES);
    end
    if (cmd.prep0) begin
      n_r[3] <= CW'(n64k);
      left_r <= left_r - LW'({n64k, 16'd0});
    end
    if (cmd.prep1) begin
      n_r[2] <= CW'(left_r >> 14);
      left_r <= left_r - ((left_r >> 14) << 12);
    end
    if (cmd.prep2) begin
      n_r[1] <= CW'(left_r >> 11);
      n_r[0] <= CW'(left_1k >> 6);
      left_r <= left_1k;
    end
    if (cmd.carve_step) begin
      if (n_cur != '0) begin
        n_r[carve_cls_r] <= n_cur - CW'(1);
        carve_off_r      <= carve_off_r + LW'(scfl_pkg::class_bytes(carve_cls_r));
      end else begin
        carve_cls_r <= carve_cls_r - 2'd1;
      end
    end
    if (cmd.finish) begin
      out_status_r <= status_w;
      out_offset_r <= grant ? 22'(head_cur) : 22'd0;
      out_bytes_r  <= grant ? scfl_pkg::class_bytes(cls_use) : 17'd0;
      out_count_r  <= count_nxt;
    end
  end

  assign sts.mode       = mode_r;
  assign sts.alloc_ok   = !too_large && !empty;
  assign sts.carve_done = (carve_cls_r == scfl_pkg::CLS_64) && (n_cur == '0);

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_offset_r;
  assign out_granted_bytes  = out_bytes_r;
  assign out_free_count     = out_count_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wb |-> (head_cur != '0))
    else $error("pop from an empty list");

  a_init_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init_start |=> (count_r == '0))
    else $error("block count not cleared at the start of carving");

endmodule

@@ rtl/size_class_free_list_allocator_unit.sv @@
// Top level of the size-class free-list allocator: controller, datapath and ports.
// Free, a refused allocate and the unused mode finish in the execute state, and the result
// strobe is registered from it; busy drops as the strobe rises, and only then is a new command
// taken. A granted allocate adds a write-back state for the registered read of the next-link
// memory. Initialize runs three preparation states, then carve steps, one write per carved block.
// Reset empties all lists, clears the count and sets pool_bytes to 1 MB; no clearing pass.
module size_class_free_list_allocator_unit #(
  parameter int unsigned MAX_POOL_BYTES = 4194304,
  parameter int unsigned HEADER_BYTES   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [22:0] in_size_bytes,
  input  logic [21:0] in_block_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [21:0] out_granted_offset,
  output logic [16:0] out_granted_bytes,
  output logic [16:0] out_free_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [22:0] cfg_pool_bytes
);

  scfl_pkg::ctrl_cmd_t cmd;
  scfl_pkg::ctrl_sts_t sts;

  // The configuration word is always taken at once.
  assign cfg_ready = 1'b1;

  scfl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  scfl_dp #(
    .MAX_POOL_BYTES (MAX_POOL_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_pool_bytes     (cfg_pool_bytes),
    .in_mode            (in_mode),
    .in_size_bytes      (in_size_bytes),
    .in_block_offset    (in_block_offset),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset),
    .out_granted_bytes  (out_granted_bytes),
    .out_free_count     (out_free_count)
  );

endmodule
